### rtl/bfa_pkg.sv
// shared constants, codes and control structs of the bitmap frame allocator
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 64;

    localparam int FIELD_W   = 52;
    localparam int FCNT_W    = 13;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam int CAPACITY  = NUM_WORDS * WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = ADDR_W + BIT_W;
    localparam int LIM_W     = $clog2(CAPACITY + 1);
    localparam int LWORD_W   = LIM_W - BIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 1'd1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic load;
        logic scan;
        logic mark;
        logic oom;
        logic rel_chk;
        logic rel_rd;
        logic rel_wr;
        logic grant;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic hit;
        logic miss_end;
        logic rel_write;
    } sts_t;

endpackage

### rtl/bfa_dp.sv
// datapath: bitmap memory, config registers, scan pointer and result registers
`timescale 1ns / 1ps

module bfa_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bfa_pkg::FIELD_W-1:0]           cfg_data,
    input  logic                                  opcode,
    input  logic [bfa_pkg::FIELD_W-1:0]           frame_number,
    input  bfa_pkg::cmd_t                         cmd,
    output bfa_pkg::sts_t                         sts,
    output logic [bfa_pkg::STATUS_W-1:0]          status,
    output logic [bfa_pkg::FIELD_W-1:0]           granted_frame
);

    logic [bfa_pkg::WORD_BITS-1:0] mem_reg [bfa_pkg::NUM_WORDS];
    logic [bfa_pkg::NUM_WORDS-1:0] vld_reg;
    logic [bfa_pkg::WORD_BITS-1:0] rdata_reg;
    logic                          rvld_reg;

    logic [bfa_pkg::FCNT_W-1:0]    fcnt_reg;
    logic [bfa_pkg::FIELD_W-1:0]   base_reg;
    logic [bfa_pkg::FIELD_W-1:0]   frame_reg;

    logic [bfa_pkg::ADDR_W-1:0]    ptr_reg;
    logic [bfa_pkg::ADDR_W-1:0]    chk_idx_reg;
    logic                          chk_vld_reg;
    logic [bfa_pkg::IDX_W-1:0]     hit_idx_reg;
    logic [bfa_pkg::IDX_W-1:0]     rel_idx_reg;

    logic [bfa_pkg::STATUS_W-1:0]  res_status_reg;
    logic [bfa_pkg::FIELD_W-1:0]   res_frame_reg;
    logic [bfa_pkg::STATUS_W-1:0]  status_reg;
    logic [bfa_pkg::FIELD_W-1:0]   granted_reg;

    logic [bfa_pkg::LIM_W-1:0]     limit;
    logic [bfa_pkg::LWORD_W-1:0]   lim_word;
    logic [bfa_pkg::BIT_W-1:0]     lim_rem;
    logic [bfa_pkg::WORD_BITS-1:0] cur_word;
    logic [bfa_pkg::WORD_BITS-1:0] word_mask;
    logic [bfa_pkg::WORD_BITS-1:0] free_bits;
    logic [bfa_pkg::WORD_BITS-1:0] lowest;
    logic [bfa_pkg::BIT_W-1:0]     hit_pos;
    logic                          last_word;

    logic [bfa_pkg::FIELD_W-1:0]   diff;
    logic                          below;
    logic                          in_range;

    logic                          mem_we;
    logic                          mem_re;
    logic [bfa_pkg::ADDR_W-1:0]    waddr;
    logic [bfa_pkg::ADDR_W-1:0]    raddr;
    logic [bfa_pkg::WORD_BITS-1:0] wdata;

    // effective frame bound
    always_comb
    begin
        if (32'(fcnt_reg) > 32'(bfa_pkg::CAPACITY))
        begin
            limit = bfa_pkg::LIM_W'(bfa_pkg::CAPACITY);
        end
        else
        begin
            limit = bfa_pkg::LIM_W'(fcnt_reg);
        end
    end

    assign lim_word = limit[bfa_pkg::LIM_W-1:bfa_pkg::BIT_W];
    assign lim_rem  = limit[bfa_pkg::BIT_W-1:0];

    assign cur_word = rvld_reg ? rdata_reg : '0;

    always_comb
    begin
        if (32'(chk_idx_reg) < 32'(lim_word))
        begin
            word_mask = '1;
        end
        else if (32'(chk_idx_reg) == 32'(lim_word))
        begin
            word_mask = (bfa_pkg::WORD_BITS'(1) << lim_rem) - bfa_pkg::WORD_BITS'(1);
        end
        else
        begin
            word_mask = '0;
        end
    end

    assign free_bits = ~cur_word & word_mask;
    assign lowest    = free_bits & (~free_bits + bfa_pkg::WORD_BITS'(1));

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < bfa_pkg::WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                hit_pos = hit_pos | bfa_pkg::BIT_W'(i);
            end
        end
    end

    assign last_word = (chk_idx_reg == bfa_pkg::ADDR_W'(bfa_pkg::NUM_WORDS - 1))
                    || (32'(chk_idx_reg) >= 32'(lim_word));

    // release range check
    assign diff     = frame_reg - base_reg;
    assign below    = frame_reg < base_reg;
    assign in_range = !below && (diff < bfa_pkg::FIELD_W'(limit));

    assign sts.is_release = (opcode == bfa_pkg::OP_RELEASE);
    assign sts.hit        = chk_vld_reg && (free_bits != '0);
    assign sts.miss_end   = chk_vld_reg && (free_bits == '0) && last_word;
    assign sts.rel_write  = in_range;

    // memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        waddr  = chk_idx_reg;
        raddr  = ptr_reg;
        wdata  = cur_word | lowest;
        if (cmd.scan)
        begin
            mem_re = 1'b1;
        end
        if (cmd.mark)
        begin
            mem_we = 1'b1;
        end
        if (cmd.rel_rd)
        begin
            mem_re = 1'b1;
            raddr  = rel_idx_reg[bfa_pkg::IDX_W-1:bfa_pkg::BIT_W];
        end
        if (cmd.rel_wr)
        begin
            mem_we = 1'b1;
            waddr  = rel_idx_reg[bfa_pkg::IDX_W-1:bfa_pkg::BIT_W];
            wdata  = cur_word
                   & ~(bfa_pkg::WORD_BITS'(1) << rel_idx_reg[bfa_pkg::BIT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    // word valid bits stand in for the reset clear of the bitmap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rvld_reg <= vld_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg    <= '0;
            base_reg    <= '0;
            ptr_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == bfa_pkg::CFG_FRAME_COUNT))
            begin
                fcnt_reg <= cfg_data[bfa_pkg::FCNT_W-1:0];
            end
            if (cfg_we && (cfg_index == bfa_pkg::CFG_BASE_FRAME))
            begin
                base_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                ptr_reg     <= '0;
                chk_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                ptr_reg     <= ptr_reg + bfa_pkg::ADDR_W'(1);
                chk_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_reg <= frame_number;
        end
        if (cmd.scan)
        begin
            chk_idx_reg <= ptr_reg;
        end
        if (cmd.mark)
        begin
            hit_idx_reg <= {chk_idx_reg, hit_pos};
        end
        if (cmd.oom)
        begin
            res_status_reg <= bfa_pkg::ST_OOM;
            res_frame_reg  <= '0;
        end
        if (cmd.rel_chk)
        begin
            rel_idx_reg    <= diff[bfa_pkg::IDX_W-1:0];
            res_status_reg <= (below || in_range) ? bfa_pkg::ST_OK : bfa_pkg::ST_INVALID;
            res_frame_reg  <= '0;
        end
        if (cmd.grant)
        begin
            res_status_reg <= bfa_pkg::ST_OK;
            res_frame_reg  <= base_reg + bfa_pkg::FIELD_W'(hit_idx_reg);
        end
        if (cmd.emit)
        begin
            status_reg  <= res_status_reg;
            granted_reg <= res_frame_reg;
        end
    end

    assign status        = status_reg;
    assign granted_frame = granted_reg;

endmodule

### rtl/bfa_ctrl.sv
// controller: request sequencing and both channel handshakes
`timescale 1ns / 1ps

module bfa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  bfa_pkg::sts_t sts,
    output bfa_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_GRANT   = 3'd2;
    localparam logic [2:0] S_REL_CHK = 3'd3;
    localparam logic [2:0] S_REL_RD  = 3'd4;
    localparam logic [2:0] S_REL_WR  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.is_release ? S_REL_CHK : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    cmd.mark   = 1'b1;
                    state_next = S_GRANT;
                end
                else if (sts.miss_end)
                begin
                    cmd.oom    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_GRANT:
            begin
                cmd.grant  = 1'b1;
                state_next = S_DONE;
            end
            S_REL_CHK:
            begin
                cmd.rel_chk = 1'b1;
                state_next  = sts.rel_write ? S_REL_RD : S_DONE;
            end
            S_REL_RD:
            begin
                cmd.rel_rd = 1'b1;
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                cmd.rel_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/bitmap_frame_allocator_top.sv
// top level of the first-fit bitmap page frame allocator
// allocate: scans the bitmap from word 0, one bitmap word checked per cycle
// release: a read-modify-write of one bitmap word, skipped when the release is ignored
// one request is in flight at a time; the next is taken the cycle after its result is loaded
// into the output beat register, which may still wait on out_stall
// reset clears config, control and word valid bits, so the bitmap reads as all free
`timescale 1ns / 1ps

module bitmap_frame_allocator_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bfa_pkg::FIELD_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic [bfa_pkg::FIELD_W-1:0]           frame_number,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [bfa_pkg::STATUS_W-1:0]          status,
    output logic [bfa_pkg::FIELD_W-1:0]           granted_frame
);

    bfa_pkg::cmd_t cmd;
    bfa_pkg::sts_t sts;

    bfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfa_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .frame_number  (frame_number),
        .cmd           (cmd),
        .sts           (sts),
        .status        (status),
        .granted_frame (granted_frame)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input not stalled after accepting a beat");

    a_fail_has_no_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status != bfa_pkg::ST_OK)) |-> (granted_frame == '0)
    ) else $error("failed request carries a granted frame");

    a_hit_miss_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(sts.hit && sts.miss_end)
    ) else $error("scan reports hit and end of map together");

    a_emit_sets_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid
    ) else $error("result beat not presented after emit");

endmodule

### bench/tb_bitmap_frame_allocator_top.sv
// self-checking testbench of the bitmap frame allocator with a first-fit predictor and scoreboard
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator_top;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int FILL_FRAMES = 1024;
    localparam logic [bfa_pkg::FIELD_W-1:0] FRAME_MAX = '1;

    typedef struct packed {
        logic [bfa_pkg::STATUS_W-1:0] status;
        logic [bfa_pkg::FIELD_W-1:0]  frame;
    } grant_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index = bfa_pkg::CFG_FRAME_COUNT;
    logic [bfa_pkg::FIELD_W-1:0]   cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          opcode = bfa_pkg::OP_ALLOC;
    logic [bfa_pkg::FIELD_W-1:0]   frame_number = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [bfa_pkg::STATUS_W-1:0]  status;
    logic [bfa_pkg::FIELD_W-1:0]   granted_frame;

    logic [bfa_pkg::WORD_BITS-1:0] frame_used [bfa_pkg::NUM_WORDS];
    logic [bfa_pkg::FCNT_W-1:0]    model_frame_count = '0;
    logic [bfa_pkg::FIELD_W-1:0]   model_base = '0;

    grant_t pending_grants [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int grants_ok = 0;
    int grants_oom = 0;
    int releases_bad = 0;
    int cycle_count = 0;

    bitmap_frame_allocator_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .frame_number  (frame_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_frame (granted_frame)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles, %0d beats still expected",
                     $time, cycle_count, pending_grants.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // scoreboard: each output beat against the oldest predicted grant
    always @(posedge clk)
    begin : check_beat
        grant_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected beat: expected none, got status %0d frame %h",
                         $time, status, granted_frame);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (status !== want.status)
                begin
                    mismatches++;
                    $display("%0t status mismatch: expected %0d, got %0d",
                             $time, want.status, status);
                end
                if (granted_frame !== want.frame)
                begin
                    mismatches++;
                    $display("%0t granted_frame mismatch: expected %h, got %h",
                             $time, want.frame, granted_frame);
                end
            end
        end
    end

    // first-fit over the used map, below the smaller of frame count and capacity; in-range releases clear their bit
    function automatic grant_t compute_grant(input logic op,
                                             input logic [bfa_pkg::FIELD_W-1:0] fn);
        grant_t g;
        int lim;
        int idx;
        logic [bfa_pkg::FIELD_W-1:0] offs;
        g.status = bfa_pkg::ST_OK;
        g.frame = '0;
        lim = (int'(model_frame_count) < bfa_pkg::CAPACITY) ? int'(model_frame_count)
                                                             : bfa_pkg::CAPACITY;
        if (op == bfa_pkg::OP_ALLOC)
        begin
            g.status = bfa_pkg::ST_OOM;
            for (int w = 0; w < bfa_pkg::NUM_WORDS && g.status == bfa_pkg::ST_OOM; w++)
            begin
                if (w * bfa_pkg::WORD_BITS >= lim)
                    break;
                if (&frame_used[w])
                    continue;
                for (int b = 0; b < bfa_pkg::WORD_BITS; b++)
                begin
                    if (!frame_used[w][b] && w * bfa_pkg::WORD_BITS + b < lim)
                    begin
                        frame_used[w][b] = 1'b1;
                        g.status = bfa_pkg::ST_OK;
                        g.frame = model_base
                                + bfa_pkg::FIELD_W'(w * bfa_pkg::WORD_BITS + b);
                        break;
                    end
                end
            end
            if (g.status == bfa_pkg::ST_OK)
                grants_ok++;
            else
                grants_oom++;
        end
        else if (fn >= model_base)
        begin
            offs = fn - model_base;
            if (offs < bfa_pkg::FIELD_W'(lim))
            begin
                idx = int'(offs);
                frame_used[idx / bfa_pkg::WORD_BITS][idx % bfa_pkg::WORD_BITS] = 1'b0;
            end
            else
            begin
                g.status = bfa_pkg::ST_INVALID;
                releases_bad++;
            end
        end
        return g;
    endfunction

    function automatic logic [bfa_pkg::FIELD_W-1:0] rand_frame();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[bfa_pkg::FIELD_W-1:0];
    endfunction

    task automatic send_beat(input logic op, input logic [bfa_pkg::FIELD_W-1:0] fn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        frame_number <= fn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_grants.push_back(compute_grant(op, fn));
        beats_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only called once the block has drained
    task automatic set_config(input logic [bfa_pkg::FCNT_W-1:0] fcount,
                              input logic [bfa_pkg::FIELD_W-1:0] base);
        cfg_we <= 1'b1;
        cfg_index <= bfa_pkg::CFG_FRAME_COUNT;
        cfg_data <= bfa_pkg::FIELD_W'(fcount);
        @(posedge clk);
        cfg_index <= bfa_pkg::CFG_BASE_FRAME;
        cfg_data <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_frame_count = fcount;
        model_base = base;
        @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    task automatic run_traffic(input int beats, input int span, input int alloc_pct);
        int pick;
        for (int i = 0; i < beats; i++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(199) == 0)
                wait_idle();
            if (pick < alloc_pct)
                send_beat(bfa_pkg::OP_ALLOC, rand_frame());
            else if (pick < 90)
                send_beat(bfa_pkg::OP_RELEASE,
                          model_base + bfa_pkg::FIELD_W'($urandom_range(span + 7)));
            else if (pick < 95)
                send_beat(bfa_pkg::OP_RELEASE,
                          model_base - bfa_pkg::FIELD_W'($urandom_range(1, 64)));
            else
                send_beat(bfa_pkg::OP_RELEASE, rand_frame());
        end
    endtask

    // zero frame count after reset: nothing to grant, every release out of range
    task automatic test_reset_defaults();
        set_idling(0);
        send_beat(bfa_pkg::OP_ALLOC, '0);
        send_beat(bfa_pkg::OP_RELEASE, '0);
        send_beat(bfa_pkg::OP_RELEASE, FRAME_MAX);
        wait_idle();
    endtask

    task automatic test_edge_cases();
        set_config(13'd3, FRAME_MAX);
        send_beat(bfa_pkg::OP_ALLOC, FRAME_MAX);
        send_beat(bfa_pkg::OP_ALLOC, '0);
        send_beat(bfa_pkg::OP_ALLOC, '0);
        send_beat(bfa_pkg::OP_ALLOC, '0);
        send_beat(bfa_pkg::OP_RELEASE, bfa_pkg::FIELD_W'(5));
        send_beat(bfa_pkg::OP_RELEASE, FRAME_MAX);
        send_beat(bfa_pkg::OP_ALLOC, '0);
        wait_idle();
        set_config(13'd8191, '0);
        send_beat(bfa_pkg::OP_RELEASE, bfa_pkg::FIELD_W'(bfa_pkg::CAPACITY));
        send_beat(bfa_pkg::OP_RELEASE, FRAME_MAX);
        send_beat(bfa_pkg::OP_RELEASE, bfa_pkg::FIELD_W'(bfa_pkg::CAPACITY - 1));
        send_beat(bfa_pkg::OP_RELEASE, bfa_pkg::FIELD_W'(1));
        send_beat(bfa_pkg::OP_ALLOC, '0);
        send_beat(bfa_pkg::OP_ALLOC, '0);
        wait_idle();
        set_config(13'd64, bfa_pkg::FIELD_W'(100));
        send_beat(bfa_pkg::OP_RELEASE, bfa_pkg::FIELD_W'(99));
        send_beat(bfa_pkg::OP_RELEASE, bfa_pkg::FIELD_W'(164));
        send_beat(bfa_pkg::OP_RELEASE, bfa_pkg::FIELD_W'(163));
        send_beat(bfa_pkg::OP_ALLOC, '0);
        wait_idle();
    endtask

    task automatic test_small_pools();
        logic [bfa_pkg::FCNT_W-1:0] counts [4];
        counts[0] = 13'd1;
        counts[1] = 13'd64;
        counts[2] = 13'd65;
        counts[3] = bfa_pkg::FCNT_W'($urandom_range(2, 200));
        for (int m = 0; m < 4; m++)
        begin
            set_config(counts[m], (m == 0) ? '0 : rand_frame());
            set_idling(m);
            run_traffic(125, int'(counts[m]), 55);
            wait_idle();
        end
    endtask

    // allocate until the low frames are all used, then a few more to hit out of memory
    task automatic test_fill_capacity();
        set_config(bfa_pkg::FCNT_W'(FILL_FRAMES), '0);
        set_idling(0);
        for (int i = 0; i < FILL_FRAMES + 4; i++)
            send_beat(bfa_pkg::OP_ALLOC, rand_frame());
        wait_idle();
    endtask

    // full low words: releases punch holes anywhere, allocates must scan past them
    task automatic test_full_pool_churn();
        logic [bfa_pkg::FCNT_W-1:0]  counts [4];
        logic [bfa_pkg::FIELD_W-1:0] bases [4];
        counts[0] = 13'd8191;
        counts[1] = 13'd4096;
        counts[2] = 13'd4095;
        counts[3] = 13'd4000;
        bases[0] = rand_frame();
        bases[1] = FRAME_MAX;
        bases[2] = '0;
        bases[3] = rand_frame();
        for (int m = 0; m < 4; m++)
        begin
            set_config(counts[m], bases[m]);
            set_idling(3 - m);
            run_traffic(60, bfa_pkg::CAPACITY, 50);
            wait_idle();
        end
    endtask

    initial
    begin
        foreach (frame_used[w])
            frame_used[w] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_edge_cases();
        test_small_pools();
        test_fill_capacity();
        test_full_pool_churn();

        wait_idle();
        repeat (bfa_pkg::NUM_WORDS + 8) @(posedge clk);
        if (pending_grants.size() != 0)
        begin
            mismatches++;
            $display("%0t %0d expected beats never arrived", $time, pending_grants.size());
        end
        $display("%0d request beats: %0d grants, %0d out of memory, %0d releases out of range",
                 beats_sent, grants_ok, grants_oom, releases_bad);
        $display("frame counts 0 to 8191, bases at both ends with wrap, low words filled");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
